// ===== src/mtsf_pkg.sv =====
// ----------------------------------------------------------------------------
// mtsf_pkg
// shared constants, codes and types of the multitouch slot to frame converter
// ----------------------------------------------------------------------------
package mtsf_pkg;

  localparam int SLOTS_DEF = 10;

  localparam int TYPE_W  = 16;
  localparam int CODE_W  = 16;
  localparam int VALUE_W = 32;
  localparam int COORD_W = 16;
  localparam int SCALE_W = 24;
  localparam int ISLOT_W = 4;
  localparam int REQ_W   = 2;
  localparam int CFG_IDX_W = 1;

  localparam logic [ISLOT_W-1:0] INJECT_SLOT_RST  = 4'd9;
  localparam logic [SCALE_W-1:0] INJECT_SCALE_RST = 24'd65536;

  // request kinds
  localparam logic [REQ_W-1:0] REQ_RAW      = 2'd0;
  localparam logic [REQ_W-1:0] REQ_INJ_MOVE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_INJ_UP   = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INJECT_SLOT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INJECT_SCALE = 1'd1;

  // event types
  localparam logic [TYPE_W-1:0] T_SYN = 16'd0;
  localparam logic [TYPE_W-1:0] T_KEY = 16'd1;
  localparam logic [TYPE_W-1:0] T_ABS = 16'd3;

  // event codes
  localparam logic [CODE_W-1:0] C_REPORT   = 16'd0;
  localparam logic [CODE_W-1:0] C_MTREPORT = 16'd2;
  localparam logic [CODE_W-1:0] C_SLOT     = 16'h2f;
  localparam logic [CODE_W-1:0] C_POSX     = 16'h35;
  localparam logic [CODE_W-1:0] C_POSY     = 16'h36;
  localparam logic [CODE_W-1:0] C_TRACK    = 16'h39;
  localparam logic [CODE_W-1:0] C_BACK     = 16'd158;
  localparam logic [CODE_W-1:0] C_APPSEL   = 16'd580;

  localparam logic [VALUE_W-1:0] TRACK_LIFTED = 32'hffff_ffff;

  typedef enum logic [2:0] {
    S_IDLE,
    S_KEY,
    S_SCAN,
    S_X,
    S_Y,
    S_SEP,
    S_NONE,
    S_REP
  } seq_state_t;

  typedef struct packed {
    logic                      frame;
    logic                      key;
    logic [CODE_W-1:0]         key_code;
    logic signed [VALUE_W-1:0] key_value;
  } seq_req_t;

endpackage

// ===== src/mtsf_ram.sv =====
// ----------------------------------------------------------------------------
// mtsf_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module mtsf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 10,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/mtsf_seq.sv =====
// ----------------------------------------------------------------------------
// mtsf_seq
// frame sequencer: walks the slot table for frames, passes keys on and drives the output register
// ----------------------------------------------------------------------------
module mtsf_seq #(
  parameter int SLOTS = mtsf_pkg::SLOTS_DEF,
  parameter int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic                             clk,
  input  logic                             rst,
  input  mtsf_pkg::seq_req_t               req,
  output logic                             busy,
  output logic [IW-1:0]                    rd_idx,
  input  logic [SLOTS-1:0]                 down,
  input  logic [mtsf_pkg::VALUE_W-1:0]     rd_x,
  input  logic [mtsf_pkg::VALUE_W-1:0]     rd_y,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [63:0]                      m_tdata,   // out_type, out_code, out_value
  output logic                             m_tlast
);

  import mtsf_pkg::*;

  localparam int CW = $clog2(SLOTS + 1);

  seq_state_t state, state_next;
  logic [CW-1:0] idx, idx_next;
  logic          found, found_next;
  logic [CODE_W-1:0]         key_code;
  logic signed [VALUE_W-1:0] key_value;

  logic                      out_free;
  logic                      load;
  logic [TYPE_W-1:0]         ld_type;
  logic [CODE_W-1:0]         ld_code;
  logic [VALUE_W-1:0]        ld_value;
  logic                      ld_last;

  assign out_free = !m_tvalid || m_tready;
  assign busy     = (state != S_IDLE);
  assign rd_idx   = idx[IW-1:0];

  always_comb begin
    state_next = state;
    idx_next   = idx;
    found_next = found;
    load       = 1'b0;
    ld_type    = T_SYN;
    ld_code    = C_MTREPORT;
    ld_value   = '0;
    ld_last    = 1'b0;
    case (state)
      S_IDLE: begin
        if (req.frame) begin
          idx_next   = '0;
          found_next = 1'b0;
          state_next = S_SCAN;
        end else if (req.key) begin
          state_next = S_KEY;
        end
      end
      S_KEY: begin
        if (out_free) begin
          load       = 1'b1;
          ld_type    = T_KEY;
          ld_code    = key_code;
          ld_value   = key_value;
          ld_last    = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_SCAN: begin
        if (idx == CW'(SLOTS)) begin
          state_next = found ? S_REP : S_NONE;
        end else if (down[idx[IW-1:0]]) begin
          state_next = S_X;
        end else begin
          idx_next = idx + CW'(1);
        end
      end
      S_X: begin
        if (out_free) begin
          load       = 1'b1;
          ld_type    = T_ABS;
          ld_code    = C_POSX;
          ld_value   = rd_x;
          state_next = S_Y;
        end
      end
      S_Y: begin
        if (out_free) begin
          load       = 1'b1;
          ld_type    = T_ABS;
          ld_code    = C_POSY;
          ld_value   = rd_y;
          state_next = S_SEP;
        end
      end
      S_SEP: begin
        if (out_free) begin
          load       = 1'b1;
          found_next = 1'b1;
          idx_next   = idx + CW'(1);
          state_next = S_SCAN;
        end
      end
      S_NONE: begin
        if (out_free) begin
          load       = 1'b1;
          state_next = S_REP;
        end
      end
      S_REP: begin
        if (out_free) begin
          load       = 1'b1;
          ld_code    = C_REPORT;
          ld_last    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      idx      <= '0;
      found    <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      found <= found_next;
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && req.key) begin
      key_code  <= req.key_code;
      key_value <= req.key_value;
    end
    if (load) begin
      m_tdata <= {ld_value, ld_code, ld_type};
      m_tlast <= ld_last;
    end
  end

  a_req_when_idle: assert property (@(posedge clk) disable iff (rst)
    (req.frame || req.key) |-> (state == S_IDLE))
    else $error("request issued while sequencer busy");

  a_x_slot_down: assert property (@(posedge clk) disable iff (rst)
    (state == S_X) |-> (idx < CW'(SLOTS)) && down[idx[IW-1:0]])
    else $error("coordinate emitted for a slot that is not down");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    idx <= CW'(SLOTS))
    else $error("slot walk ran past the table");

  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |->
      ((m_tdata[15:0] == T_SYN && m_tdata[31:16] == C_REPORT) || m_tdata[15:0] == T_KEY))
    else $error("last set on an event that does not close a run");

endmodule

// ===== src/multitouch_slot_to_frame_converter.sv =====
// ----------------------------------------------------------------------------
// multitouch_slot_to_frame_converter
// slot-form touch events in, anonymous-contact frames out
// ----------------------------------------------------------------------------
// raw position, slot and tracking events: taken in the accepting cycle, no output
// key pass-through: captured in the accepting cycle, then loaded into the output register once it is free
// frame: accepting cycle, a scan step per table slot, x, y and separator events per down slot,
//   then the closing report, preceded by an empty separator when no slot is down
// output stalls hold the walk; coordinates sit in two rams read one slot a cycle
// reset clears down flags, ram valid bits and current slot at once, no clearing pass
module multitouch_slot_to_frame_converter #(
  parameter int SLOTS = mtsf_pkg::SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [95:0]                   s_tdata,   // ev_type, ev_code, ev_value, inject_x, inject_y
  input  logic [mtsf_pkg::REQ_W-1:0]    s_tuser,   // req_type
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [63:0]                   m_tdata,   // out_type, out_code, out_value
  output logic                          m_tlast,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mtsf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mtsf_pkg::SCALE_W-1:0]  cfg_data
);

  import mtsf_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [ISLOT_W-1:0] inject_slot;
  logic [SCALE_W-1:0] inject_scale;

  logic [REQ_W-1:0]          req_type;
  logic [TYPE_W-1:0]         ev_type;
  logic [CODE_W-1:0]         ev_code;
  logic signed [VALUE_W-1:0] ev_value;
  logic [COORD_W-1:0]        inject_x;
  logic [COORD_W-1:0]        inject_y;

  logic [SLOTS-1:0] slot_down;
  logic [SLOTS-1:0] x_valid;
  logic [SLOTS-1:0] y_valid;
  logic [IW-1:0]    current_slot;

  logic acc, busy, is_raw, is_abs, inj, inj_ok, inj_move, inj_up;
  logic [IW-1:0] inj_idx;
  logic [39:0]   prod_x, prod_y;
  logic          x_we, y_we;
  logic [IW-1:0] w_idx;
  logic [VALUE_W-1:0] x_wdata, y_wdata;
  logic [IW-1:0] rd_idx;
  logic [VALUE_W-1:0] ram_x, ram_y, rd_x, rd_y;
  seq_req_t seq_req;

  assign {inject_y, inject_x, ev_value, ev_code, ev_type} = s_tdata;
  assign req_type  = s_tuser;
  assign s_tready  = !busy;
  assign cfg_ready = 1'b1;
  assign acc       = s_tvalid && s_tready;

  assign is_raw   = (req_type == REQ_RAW);
  assign is_abs   = is_raw && (ev_type == T_ABS);
  assign inj_move = (req_type == REQ_INJ_MOVE);
  assign inj_up   = (req_type == REQ_INJ_UP);
  assign inj      = inj_move || inj_up;
  assign inj_ok   = ({1'b0, inject_slot} < 5'(SLOTS));
  assign inj_idx  = inject_slot[IW-1:0];

  // unsigned q8.16 scaling, truncated
  assign prod_x = 40'(inject_x) * 40'(inject_scale);
  assign prod_y = 40'(inject_y) * 40'(inject_scale);

  assign w_idx   = inj ? inj_idx : current_slot;
  assign x_we    = acc && ((inj_move && inj_ok) || (is_abs && ev_code == C_POSX));
  assign y_we    = acc && ((inj_move && inj_ok) || (is_abs && ev_code == C_POSY));
  assign x_wdata = inj ? {8'd0, prod_x[39:16]} : ev_value;
  assign y_wdata = inj ? {8'd0, prod_y[39:16]} : ev_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      inject_slot  <= INJECT_SLOT_RST;
      inject_scale <= INJECT_SCALE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_INJECT_SLOT:  inject_slot  <= cfg_data[ISLOT_W-1:0];
        REG_INJECT_SCALE: inject_scale <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_down    <= '0;
      x_valid      <= '0;
      y_valid      <= '0;
      current_slot <= '0;
    end else if (acc) begin
      if (x_we) begin
        x_valid[w_idx] <= 1'b1;
      end
      if (y_we) begin
        y_valid[w_idx] <= 1'b1;
      end
      if (inj && inj_ok) begin
        slot_down[inj_idx] <= inj_move;
      end
      if (is_abs && ev_code == C_SLOT && $unsigned(ev_value) < 32'(SLOTS)) begin
        current_slot <= ev_value[IW-1:0];
      end
      if (is_abs && ev_code == C_TRACK) begin
        slot_down[current_slot] <= ($unsigned(ev_value) != TRACK_LIFTED);
      end
    end
  end

  mtsf_ram #(.WIDTH(VALUE_W), .DEPTH(SLOTS)) u_ram_x (
    .clk   (clk),
    .we    (x_we),
    .waddr (w_idx),
    .wdata (x_wdata),
    .raddr (rd_idx),
    .rdata (ram_x)
  );

  mtsf_ram #(.WIDTH(VALUE_W), .DEPTH(SLOTS)) u_ram_y (
    .clk   (clk),
    .we    (y_we),
    .waddr (w_idx),
    .wdata (y_wdata),
    .raddr (rd_idx),
    .rdata (ram_y)
  );

  // never-written entries read as zero; table is not written during a walk
  assign rd_x = x_valid[rd_idx] ? ram_x : '0;
  assign rd_y = y_valid[rd_idx] ? ram_y : '0;

  always_comb begin
    seq_req.frame     = acc && (inj || (is_raw && ev_type == T_SYN && ev_code == C_REPORT));
    seq_req.key       = acc && is_raw && ev_type == T_KEY &&
                        (ev_code == C_BACK || ev_code == C_APPSEL);
    seq_req.key_code  = ev_code;
    seq_req.key_value = ev_value;
  end

  mtsf_seq #(.SLOTS(SLOTS)) u_seq (
    .clk      (clk),
    .rst      (rst),
    .req      (seq_req),
    .busy     (busy),
    .rd_idx   (rd_idx),
    .down     (slot_down),
    .rd_x     (rd_x),
    .rd_y     (rd_y),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

// ===== test/mtsf_checker.sv =====
// ----------------------------------------------------------------------------
// mtsf_checker
// watches request, event and register channels, predicts and compares events
// ----------------------------------------------------------------------------
module mtsf_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  input  logic [95:0]                   s_tdata,   // ev_type, ev_code, ev_value, inject_x, inject_y
  input  logic [mtsf_pkg::REQ_W-1:0]    s_tuser,   // req_type
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic [63:0]                   m_tdata,   // out_type, out_code, out_value
  input  logic                          m_tlast,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [mtsf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mtsf_pkg::SCALE_W-1:0]  cfg_data,
  output int                            fail_count,
  output int                            pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import mtsf_pkg::*;

  typedef struct packed {
    logic [TYPE_W-1:0]  kind;
    logic [CODE_W-1:0]  code;
    logic [VALUE_W-1:0] value;
    logic               last;
  } touch_event_t;

  touch_event_t       event_queue[$];
  logic               contact_down [SLOTS_DEF];
  logic [VALUE_W-1:0] contact_x [SLOTS_DEF];
  logic [VALUE_W-1:0] contact_y [SLOTS_DEF];
  logic [ISLOT_W-1:0] sel_slot;
  logic [ISLOT_W-1:0] touch_slot;
  logic [SCALE_W-1:0] touch_scale;

  initial begin
    fail_count = 0;
    pending = 0;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    fail_count++;
  endtask

  function automatic logic [VALUE_W-1:0] scaled(input logic [COORD_W-1:0] c);
    logic [COORD_W+SCALE_W-1:0] prod;
    prod = c * touch_scale;
    return VALUE_W'(prod >> 16);
  endfunction

  task automatic queue_event(input logic [TYPE_W-1:0] kind, input logic [CODE_W-1:0] code,
                             input logic [VALUE_W-1:0] value, input logic last);
    touch_event_t ev;
    ev = '{kind: kind, code: code, value: value, last: last};
    event_queue.push_back(ev);
  endtask

  task automatic queue_frame();
    int contacts;
    contacts = 0;
    for (int i = 0; i < SLOTS_DEF; i++) begin
      if (contact_down[i]) begin
        queue_event(T_ABS, C_POSX, contact_x[i], 1'b0);
        queue_event(T_ABS, C_POSY, contact_y[i], 1'b0);
        queue_event(T_SYN, C_MTREPORT, '0, 1'b0);
        contacts++;
      end
    end
    if (contacts == 0) queue_event(T_SYN, C_MTREPORT, '0, 1'b0);
    queue_event(T_SYN, C_REPORT, '0, 1'b1);
  endtask

  task automatic apply_request(input logic [REQ_W-1:0] req, input logic [95:0] data);
    logic [TYPE_W-1:0]  kind;
    logic [CODE_W-1:0]  code;
    logic [VALUE_W-1:0] value;
    kind  = data[15:0];
    code  = data[31:16];
    value = data[63:32];
    case (req)
      REQ_INJ_MOVE, REQ_INJ_UP: begin
        if (touch_slot < SLOTS_DEF) begin
          if (req == REQ_INJ_MOVE) begin
            contact_x[touch_slot]    = scaled(data[79:64]);
            contact_y[touch_slot]    = scaled(data[95:80]);
            contact_down[touch_slot] = 1'b1;
          end else begin
            contact_down[touch_slot] = 1'b0;
          end
        end
        queue_frame();
      end
      REQ_RAW: begin
        if (kind == T_ABS) begin
          if (code == C_SLOT) begin
            if (value < SLOTS_DEF) sel_slot = value[ISLOT_W-1:0];
          end else if (code == C_TRACK) begin
            contact_down[sel_slot] = (value != TRACK_LIFTED);
          end else if (code == C_POSX) begin
            contact_x[sel_slot] = value;
          end else if (code == C_POSY) begin
            contact_y[sel_slot] = value;
          end
        end else if (kind == T_SYN && code == C_REPORT) begin
          queue_frame();
        end else if (kind == T_KEY && (code == C_BACK || code == C_APPSEL)) begin
          queue_event(kind, code, value, 1'b1);
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    touch_event_t want;
    if (rst) begin
      event_queue.delete();
      for (int i = 0; i < SLOTS_DEF; i++) begin
        contact_down[i] = 1'b0;
        contact_x[i]    = '0;
        contact_y[i]    = '0;
      end
      sel_slot    = '0;
      touch_slot  = INJECT_SLOT_RST;
      touch_scale = INJECT_SCALE_RST;
    end else begin
      // results of earlier requests first, a request accepted now adds after them
      if (m_tvalid && m_tready) begin
        if (event_queue.size() == 0) begin
          report_mismatch($sformatf("unexpected event type %0d code %0d value %0d",
                                    m_tdata[15:0], m_tdata[31:16], m_tdata[63:32]));
        end else begin
          want = event_queue.pop_front();
          if (m_tdata[15:0] !== want.kind)
            report_mismatch($sformatf("type %0d, wanted %0d", m_tdata[15:0], want.kind));
          if (m_tdata[31:16] !== want.code)
            report_mismatch($sformatf("code %0d, wanted %0d", m_tdata[31:16], want.code));
          if (m_tdata[63:32] !== want.value)
            report_mismatch($sformatf("value %h, wanted %h", m_tdata[63:32], want.value));
          if (m_tlast !== want.last)
            report_mismatch($sformatf("last %b, wanted %b", m_tlast, want.last));
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_INJECT_SLOT) touch_slot = cfg_data[ISLOT_W-1:0];
        else touch_scale = cfg_data;
      end
      if (s_tvalid && s_tready) apply_request(s_tuser, s_tdata);
    end
    pending <= event_queue.size();
  end

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// touch requests, injected touches and register writes under random gaps
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mtsf_pkg::*;

  localparam int               RESET_CYCLES = 10;
  localparam int               FRAME_CYCLES = 4 * SLOTS_DEF + 3;
  localparam int               SETTLE       = FRAME_CYCLES + 8;
  localparam int               CYCLE_LIMIT  = 500000;
  localparam int               PHASE_ITEMS  = 38;
  localparam logic [REQ_W-1:0] REQ_NONE     = 2'd3;
  localparam logic [SCALE_W-1:0] SCALE_MAX  = 24'hffffff;
  localparam logic [SCALE_W-1:0] SCALE_HALF = 24'h008000;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [95:0]          s_tdata = '0;
  logic [REQ_W-1:0]     s_tuser = REQ_RAW;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [63:0]          m_tdata;
  logic                 m_tlast;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_INJECT_SLOT;
  logic [SCALE_W-1:0]   cfg_data = '0;

  int fail_count;
  int pending;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int sent = 0;

  always #2 clk = ~clk;

  multitouch_slot_to_frame_converter uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  mtsf_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  task automatic send_request(input logic [REQ_W-1:0] req, input logic [TYPE_W-1:0] kind,
                              input logic [CODE_W-1:0] code, input logic [VALUE_W-1:0] value,
                              input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= {y, x, value, code, kind};
    do @(posedge clk); while (!s_tready);
    sent++;
  endtask

  task automatic send_raw(input logic [TYPE_W-1:0] kind, input logic [CODE_W-1:0] code,
                          input logic [VALUE_W-1:0] value);
    send_request(REQ_RAW, kind, code, value, COORD_W'($urandom), COORD_W'($urandom));
  endtask

  task automatic send_touch(input logic [REQ_W-1:0] req, input logic [COORD_W-1:0] x,
                            input logic [COORD_W-1:0] y);
    send_request(req, TYPE_W'($urandom), CODE_W'($urandom), $urandom, x, y);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SCALE_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // slot select, tracking id and position updates for a few slots, then a report
  task automatic touch_burst();
    int contacts;
    logic [VALUE_W-1:0] slot_sel;
    logic [VALUE_W-1:0] track_id;
    contacts = $urandom_range(1, 3);
    for (int i = 0; i < contacts; i++) begin
      case ($urandom_range(9))
        0:       slot_sel = $urandom;
        1:       slot_sel = $urandom_range(SLOTS_DEF, 15);
        default: slot_sel = $urandom_range(SLOTS_DEF - 1);
      endcase
      case ($urandom_range(7))
        0, 1:    track_id = TRACK_LIFTED;
        2:       track_id = $urandom;
        default: track_id = $urandom_range(1000);
      endcase
      send_raw(T_ABS, C_SLOT, slot_sel);
      if ($urandom_range(4) != 0) send_raw(T_ABS, C_TRACK, track_id);
      if ($urandom_range(4) != 0) send_raw(T_ABS, C_POSX, $urandom);
      if ($urandom_range(4) != 0) send_raw(T_ABS, C_POSY, $urandom);
    end
    send_raw(T_SYN, C_REPORT, $urandom);
  endtask

  task automatic random_item();
    int pick;
    logic [TYPE_W-1:0] kind;
    pick = $urandom_range(99);
    if (pick < 55) begin
      touch_burst();
    end else if (pick < 70) begin
      send_touch(REQ_INJ_MOVE, COORD_W'($urandom), COORD_W'($urandom));
    end else if (pick < 78) begin
      send_touch(REQ_INJ_UP, COORD_W'($urandom), COORD_W'($urandom));
    end else if (pick < 85) begin
      send_raw(T_KEY, ($urandom_range(1) != 0) ? C_BACK : C_APPSEL, $urandom);
    end else if (pick < 95) begin
      case ($urandom_range(3))
        0:       kind = T_SYN;
        1:       kind = T_KEY;
        2:       kind = T_ABS;
        default: kind = TYPE_W'($urandom);
      endcase
      send_raw(kind, CODE_W'($urandom), $urandom);
    end else begin
      send_request(REQ_NONE, TYPE_W'($urandom), CODE_W'($urandom), $urandom,
                   COORD_W'($urandom), COORD_W'($urandom));
    end
  endtask

  task automatic run_phase(input logic [ISLOT_W-1:0] slot, input logic [SCALE_W-1:0] scale);
    int target;
    target = sent + PHASE_ITEMS;
    write_reg(REG_INJECT_SLOT, slot);
    write_reg(REG_INJECT_SCALE, scale);
    while (sent < target) random_item();
    drain();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 20;
    recv_idle_pct = 59;

    // empty table, then two contacts at the table ends
    send_raw(T_SYN, C_REPORT, '0);
    send_raw(T_ABS, C_SLOT, '0);
    send_raw(T_ABS, C_TRACK, '0);
    send_raw(T_ABS, C_POSX, 32'h7fff_ffff);
    send_raw(T_ABS, C_POSY, 32'h8000_0000);
    send_raw(T_ABS, C_SLOT, SLOTS_DEF - 1);
    send_raw(T_ABS, C_TRACK, 32'h7fff_ffff);
    send_raw(T_ABS, C_POSX, '0);
    send_raw(T_ABS, C_POSY, 32'hffff_ffff);
    send_raw(T_SYN, C_REPORT, 32'hffff_ffff);
    // out of range slot selects keep the last slot, which is then lifted
    send_raw(T_ABS, C_SLOT, SLOTS_DEF);
    send_raw(T_ABS, C_SLOT, 32'hffff_ffff);
    send_raw(T_ABS, C_TRACK, TRACK_LIFTED);
    send_raw(T_SYN, C_REPORT, '0);
    // keys pass through, anything not matching on type and code is dropped
    send_raw(T_KEY, C_BACK, 32'd1);
    send_raw(T_KEY, C_APPSEL, 32'h8000_0000);
    send_raw(T_KEY, C_BACK + 16'd1, 32'd1);
    send_raw(T_KEY, C_SLOT, '0);
    send_raw(T_SYN, C_MTREPORT, '0);
    send_raw(16'hffff, 16'hffff, $urandom);
    // injected touch on the reset slot, up keeps its coordinates
    send_touch(REQ_INJ_MOVE, 16'hffff, 16'h0000);
    send_touch(REQ_INJ_MOVE, 16'h0000, 16'hffff);
    send_touch(REQ_INJ_UP, 16'hffff, 16'hffff);
    send_request(REQ_NONE, 16'hffff, 16'hffff, 32'hffff_ffff, 16'hffff, 16'hffff);
    send_raw(T_SYN, C_REPORT, '0);
    drain();

    run_phase('0, SCALE_MAX);
    run_phase(4'd15, '0);

    send_idle_pct = 59;
    recv_idle_pct = 20;
    run_phase(ISLOT_W'(SLOTS_DEF), INJECT_SCALE_RST);
    run_phase(ISLOT_W'($urandom_range(SLOTS_DEF - 1)), SCALE_W'($urandom));

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(INJECT_SLOT_RST, SCALE_W'($urandom));
    run_phase(ISLOT_W'($urandom_range(15)), SCALE_HALF);

    if (fail_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/mtsf_pkg.sv
src/mtsf_ram.sv
src/mtsf_seq.sv
src/multitouch_slot_to_frame_converter.sv
test/mtsf_checker.sv
test/tb_top.sv
